// ----- hdl/esrd_pkg.sv -----
// Shared types and constants for the encoder slew-rate detector.
`default_nettype none

package esrd_pkg;

  // Field widths
  localparam int POS_W   = 32;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 32;
  localparam int ACT_W   = 3;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Divider geometry: remainder, dividend/quotient shift register (also holds the speed sum)
  localparam int REM_W = 33;
  localparam int QD_W  = 34;
  localparam int CNT_W = 6;

  // Speed division yields 31 quotient bits
  localparam int SPD_STEPS  = 31;

  localparam logic [POS_W-1:0]  FAULT_SENTINEL = 32'h7FFF_FFFF;
  localparam logic [30:0]       SPEED_MAX      = 31'h7FFF_FFFF;
  localparam logic [RATE_W-1:0] RATE_DIVISOR   = 32'd50;

  // sum/50 taken as (sum>>1)/25 by reciprocal: ceil(2^36/25), exact for sum>>1 below 2^32
  localparam logic [RATE_W-1:0] RATE_RECIP     = 32'd2748779070;
  localparam int                RATE_SHIFT     = 36;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 2'd2;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_NONE       = 3'd0;
  localparam action_t ACT_PULL       = 3'd1;
  localparam action_t ACT_UPDATE     = 3'd2;
  localparam action_t ACT_START      = 3'd3;
  localparam action_t ACT_STOP       = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture an accepted request
    logic spd_start;   // load divider with |dpos|<<16 / dt
    logic rate_start;  // latch sum|speed| for the rate product
    logic div_step;    // one restoring step
    logic spd_write;   // shift speed history, update last sample
    logic decide;      // form a result without the rate path
    logic rate_done;   // form a guide result from the rate product
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fault;
    logic mode;
    logic spd_special;  // zero motion or saturated speed, no division
    logic need_rate;    // all speeds agree, no hold-off, no fault, speed mode
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/esrd_if.sv -----
// Valid/ready channel interfaces for poll requests and results.
`default_nettype none

interface esrd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  logic [31:0] time_ms;
  logic [31:0] current_rate;

  modport source (output valid, output position, output time_ms, output current_rate,
                  input ready);
  modport sink   (input valid, input position, input time_ms, input current_rate,
                  output ready);
endinterface

interface esrd_out_if;
  logic        valid;
  logic        ready;
  logic        fault;
  logic [2:0]  action;
  logic [31:0] pull_amount;
  logic [31:0] guide_rate;
  logic        guide_west;

  modport source (output valid, output fault, output action, output pull_amount,
                  output guide_rate, output guide_west, input ready);
  modport sink   (input valid, input fault, input action, input pull_amount,
                  input guide_rate, input guide_west, output ready);
endinterface

`default_nettype wire

// ----- hdl/esrd_ctrl.sv -----
// Sequencing state machine for the encoder slew-rate detector.
`default_nettype none

module esrd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire esrd_pkg::sts_t sts,
  output esrd_pkg::cmd_t     cmd
);
  import esrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_SDIV, S_SWR, S_DECIDE, S_RDONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  // Output register may be refilled when empty or being taken
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.fault || !sts.mode) begin
          state_nxt = S_DECIDE;
        end else if (sts.spd_special) begin
          state_nxt = S_SWR;
        end else begin
          cmd.spd_start = 1'b1;
          cnt_nxt       = CNT_W'(SPD_STEPS - 1);
          state_nxt     = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SWR;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SWR: begin
        cmd.spd_write = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.need_rate) begin
          cmd.rate_start = 1'b1;
          state_nxt      = S_RDONE;
        end else if (out_free) begin
          cmd.decide    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RDONE: begin
        if (out_free) begin
          cmd.rate_done = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, step count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/esrd_dp.sv -----
// Datapath: sample state, speed history, speed divider, rate product, result register.
`default_nettype none

module esrd_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire esrd_pkg::cmd_t                      cmd,
  output esrd_pkg::sts_t                           sts,
  input  wire logic                                cfg_we,
  input  wire logic [esrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [esrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic signed [esrd_pkg::POS_W-1:0]   in_position,
  input  wire logic [esrd_pkg::TIME_W-1:0]         in_time_ms,
  input  wire logic [esrd_pkg::RATE_W-1:0]         in_current_rate,
  output logic                                     out_fault,
  output esrd_pkg::action_t                        out_action,
  output logic signed [esrd_pkg::POS_W-1:0]        out_pull_amount,
  output logic [esrd_pkg::RATE_W-1:0]              out_guide_rate,
  output logic                                     out_guide_west
);
  import esrd_pkg::*;

  // Configuration and persistent state
  logic                  mode_r;
  logic                  invert_r;
  logic [HOLD_W-1:0]     holdoff_r;
  logic [POS_W-1:0]      last_pos_r;
  logic [TIME_W-1:0]     last_time_r;
  logic signed [POS_W-1:0] hist_r [3];
  logic                  slewing_r;
  logic [RATE_W-1:0]     saved_rate_r;

  // Captured request
  logic [POS_W-1:0]      pos_r;
  logic [TIME_W-1:0]     time_r;
  logic [RATE_W-1:0]     rate_r;
  logic                  fault_r;

  // Divider
  logic [REM_W-1:0]      rem_r;
  logic [QD_W-1:0]       qd_r;
  logic [RATE_W-1:0]     dvs_r;
  logic [REM_W-1:0]      div_sh;
  logic                  div_ge;

  // Result register
  logic                  res_fault_r;
  action_t               res_action_r;
  logic [POS_W-1:0]      res_pull_r;
  logic [RATE_W-1:0]     res_rate_r;
  logic                  res_west_r;

  // Speed terms
  logic signed [POS_W:0] dpos;
  logic                  dpos_neg;
  logic [POS_W:0]        mag;
  logic [TIME_W-1:0]     dt;
  logic                  mag_zero;
  logic                  spd_special;
  logic [30:0]           spd_mag;
  logic [POS_W-1:0]      spd_new;

  // Agreement and rate terms
  logic [RATE_W-1:0]     abs0, abs1, abs2;
  logic [QD_W-1:0]       abs_sum;
  logic                  pos3, neg3;
  logic [63:0]           rate_prod;

  // Position change and time change against the last sample
  assign dpos     = $signed({pos_r[POS_W-1], pos_r}) - $signed({last_pos_r[POS_W-1], last_pos_r});
  assign dpos_neg = dpos[POS_W];
  assign mag      = dpos_neg ? (POS_W+1)'(-dpos) : (POS_W+1)'(dpos);
  assign dt       = time_r - last_time_r;
  assign mag_zero = (mag == '0);
  // Quotient overflows 31 bits when the top dividend bits reach the divisor
  assign spd_special = mag_zero || ({14'b0, mag[POS_W:15]} >= dt);

  // Speed magnitude: division result or one of the special values
  always_comb begin
    if (mag_zero) begin
      spd_mag = '0;
    end else if (spd_special) begin
      spd_mag = SPEED_MAX;
    end else begin
      spd_mag = qd_r[30:0];
    end
  end
  assign spd_new = dpos_neg ? (0 - {1'b0, spd_mag}) : {1'b0, spd_mag};

  // Sign agreement over the history
  assign pos3 = !hist_r[0][31] && (hist_r[0] != '0) &&
                !hist_r[1][31] && (hist_r[1] != '0) &&
                !hist_r[2][31] && (hist_r[2] != '0);
  assign neg3 = hist_r[0][31] && hist_r[1][31] && hist_r[2][31];

  assign abs0    = hist_r[0][31] ? RATE_W'(-hist_r[0]) : RATE_W'(hist_r[0]);
  assign abs1    = hist_r[1][31] ? RATE_W'(-hist_r[1]) : RATE_W'(hist_r[1]);
  assign abs2    = hist_r[2][31] ? RATE_W'(-hist_r[2]) : RATE_W'(hist_r[2]);
  assign abs_sum = QD_W'(abs0) + QD_W'(abs1) + QD_W'(abs2);

  // Rate: halve the latched sum, then multiply by the reciprocal of 25
  assign rate_prod = {32'b0, qd_r[32:1]} * {32'b0, RATE_RECIP};

  // One restoring division step
  assign div_sh = {rem_r[REM_W-2:0], qd_r[QD_W-1]};
  assign div_ge = (div_sh >= {1'b0, dvs_r});

  // Status to the controller
  always_comb begin
    sts.fault       = fault_r;
    sts.mode        = mode_r;
    sts.spd_special = spd_special;
    sts.need_rate   = !fault_r && mode_r && (holdoff_r == '0) && (pos3 || neg3);
  end

  // Control state: configuration, slewing flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      invert_r  <= 1'b0;
      holdoff_r <= '0;
      slewing_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CONTROL_MODE: mode_r    <= cfg_wdata[0];
          REG_INVERT_DIR:   invert_r  <= cfg_wdata[0];
          REG_HOLDOFF:      holdoff_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.decide && !fault_r) begin
        if (holdoff_r != '0) begin
          holdoff_r <= holdoff_r - 1'b1;
        end else if (!mode_r && (pos_r != last_pos_r)) begin
          slewing_r <= slewing_r;
        end else begin
          slewing_r <= 1'b0;
        end
      end
      if (cmd.rate_done) begin
        slewing_r <= 1'b1;
      end
    end
  end

  // Sample history and speed history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r   <= '0;
      last_time_r  <= '0;
      hist_r[0]    <= '0;
      hist_r[1]    <= '0;
      hist_r[2]    <= '0;
      saved_rate_r <= '0;
    end else begin
      if (cmd.spd_write) begin
        hist_r[2]   <= hist_r[1];
        hist_r[1]   <= hist_r[0];
        hist_r[0]   <= spd_new;
        last_time_r <= time_r;
        last_pos_r  <= pos_r;
      end
      if (cmd.decide && !fault_r && (holdoff_r == '0) && !mode_r &&
          (pos_r != last_pos_r)) begin
        last_pos_r <= pos_r;
      end
      if (cmd.rate_done) begin
        saved_rate_r <= rate_r;
      end
    end
  end

  // Capture the request, negating the position when asked
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r   <= invert_r ? (0 - in_position) : in_position;
      time_r  <= in_time_ms;
      rate_r  <= in_current_rate;
      fault_r <= (in_position == FAULT_SENTINEL);
    end
  end

  // Speed divider: load, then shift one quotient bit in per step; also latch the speed sum
  always_ff @(posedge clk) begin
    if (cmd.spd_start) begin
      rem_r <= {15'b0, mag[POS_W:15]};
      qd_r  <= {mag[14:0], 16'b0, 3'b0};
      dvs_r <= dt;
    end else if (cmd.rate_start) begin
      qd_r  <= abs_sum;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? (div_sh - {1'b0, dvs_r}) : div_sh;
      qd_r  <= {qd_r[QD_W-2:0], div_ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_fault_r  <= fault_r;
      res_action_r <= ACT_NONE;
      res_pull_r   <= '0;
      res_rate_r   <= '0;
      res_west_r   <= 1'b0;
      if (!fault_r && (holdoff_r == '0)) begin
        if (!mode_r && (pos_r != last_pos_r)) begin
          res_action_r <= ACT_PULL;
          res_pull_r   <= pos_r - last_pos_r;
        end else if (slewing_r) begin
          res_action_r <= ACT_STOP;
          res_rate_r   <= saved_rate_r;
        end
      end
    end else if (cmd.rate_done) begin
      res_fault_r  <= 1'b0;
      res_action_r <= slewing_r ? ACT_UPDATE : ACT_START;
      res_pull_r   <= '0;
      res_rate_r   <= RATE_W'(rate_prod >> RATE_SHIFT);
      res_west_r   <= neg3;
    end
  end

  assign out_fault       = res_fault_r;
  assign out_action      = res_action_r;
  assign out_pull_amount = res_pull_r;
  assign out_guide_rate  = res_rate_r;
  assign out_guide_west  = res_west_r;

endmodule

`default_nettype wire

// ----- hdl/encoder_slew_rate_detector.sv -----
// Top level of the encoder slew-rate detector.
// One request in, one result out, at most one request in flight. A fault
// sample or a position-mode sample passes S_EVAL, then S_DECIDE registers
// its result. A speed-mode sample divides the position change by the time
// change in a one-bit-per-cycle restoring divider (31 steps, S_SDIV); S_SWR
// then stores the speed and S_DECIDE registers the result. When all three
// stored speeds agree and no hold-off is pending, S_DECIDE instead latches
// sum|speed| and S_RDONE registers the guide rate sum|speed|/50, formed by a
// reciprocal product. Zero motion, a zero time change or a saturated speed
// skips the divider. The next request is taken in S_IDLE, which the controller
// enters as the result is registered. A stalled output register holds the
// block until the waiting result is taken. A new request is taken while the
// previous result still waits in the output register.
`default_nettype none

module encoder_slew_rate_detector (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  esrd_in_if.sink                                  in_chan,
  esrd_out_if.source                               out_chan,
  input  wire logic                                cfg_we,
  input  wire logic [esrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [esrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import esrd_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  logic    in_ready;
  logic    out_valid;
  logic    out_fault;
  action_t out_action;
  logic signed [POS_W-1:0] out_pull_amount;
  logic [RATE_W-1:0]       out_guide_rate;
  logic    out_guide_west;

  esrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esrd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_position     (in_chan.position),
    .in_time_ms      (in_chan.time_ms),
    .in_current_rate (in_chan.current_rate),
    .out_fault       (out_fault),
    .out_action      (out_action),
    .out_pull_amount (out_pull_amount),
    .out_guide_rate  (out_guide_rate),
    .out_guide_west  (out_guide_west)
  );

  // Drive the channels
  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.fault       = out_fault;
  assign out_chan.action      = out_action;
  assign out_chan.pull_amount = out_pull_amount;
  assign out_chan.guide_rate  = out_guide_rate;
  assign out_chan.guide_west  = out_guide_west;

endmodule

`default_nettype wire

// ----- hdl/esrd_chk.sv -----
// Port-level checker for the encoder slew-rate detector, with its bind.
`default_nettype none

module esrd_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_fault,
  input wire logic [2:0]  out_action,
  input wire logic [31:0] out_pull_amount,
  input wire logic [31:0] out_guide_rate,
  input wire logic        out_guide_west
);
  import esrd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_pull_amount) && $stable(out_guide_rate) && $stable(out_fault))
    else $error("result changed while stalled");

  // Only one request in flight: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in flight");

  // A fault result carries nothing else
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_action == ACT_NONE && out_pull_amount == '0 &&
      out_guide_rate == '0 && !out_guide_west)
    else $error("fault result with payload");

  // Pull amount appears only with a pull
  a_pull_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_PULL |-> out_pull_amount == '0)
    else $error("pull amount without pull action");

  // Direction appears only when guiding starts or updates
  a_west_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_guide_west |-> out_action == ACT_UPDATE || out_action == ACT_START)
    else $error("guide direction without guide action");

endmodule

bind encoder_slew_rate_detector esrd_chk u_esrd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_fault       (out_chan.fault),
  .out_action      (out_chan.action),
  .out_pull_amount (out_chan.pull_amount),
  .out_guide_rate  (out_chan.guide_rate),
  .out_guide_west  (out_chan.guide_west)
);

`default_nettype wire
